// ===== hdl/iba_pkg.sv =====
package iba_pkg;

  localparam int BITMAP_BYTES    = 512;
  localparam int RESERVED_INODES = 2;
  localparam int TOTAL_BITS      = BITMAP_BYTES * 8;

  localparam int WORD_BITS = 64;
  localparam int POS_W     = $clog2(WORD_BITS);
  localparam int WORDS     = (TOTAL_BITS + WORD_BITS - 1) / WORD_BITS;
  localparam int ADDR_W    = (WORDS > 1) ? $clog2(WORDS) : 1;

  localparam int NUM_W     = 13;
  localparam int ST_W      = 2;
  localparam int SPAN_W    = $clog2(WORDS * WORD_BITS + 1);
  localparam int IDX_W     = (SPAN_W > NUM_W) ? SPAN_W : NUM_W;

  localparam int IN_DATA_W  = 16;
  localparam int IN_USER_W  = 1;
  localparam int OUT_DATA_W = 16;
  localparam int OUT_USER_W = ST_W;

  typedef enum logic [ST_W-1:0] {
    STS_ALLOCATED = 2'd0,
    STS_FULL      = 2'd1,
    STS_FREED     = 2'd2,
    STS_IGNORED   = 2'd3
  } status_e;

  typedef enum logic [0:0] {
    KIND_ALLOC = 1'b0,
    KIND_FREE  = 1'b1
  } kind_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PRIME,
    S_SCAN,
    S_FREE_RD,
    S_FREE_WR,
    S_OUT
  } state_e;

  typedef struct packed {
    logic load_req;
    logic addr_inc;
    logic wr_alloc;
    logic wr_free;
    logic res_alloc;
    logic res_full;
    logic res_freed;
    logic res_ignored;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic req_free;
    logic free_ok;
    logic found;
    logic last_word;
  } dp_sts_t;

endpackage

// ===== hdl/iba_dp.sv =====
module iba_dp (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic [iba_pkg::IN_DATA_W-1:0]   s_tdata_i,
  input  logic [iba_pkg::IN_USER_W-1:0]   s_tuser_i,
  input  iba_pkg::dp_cmd_t                cmd_i,
  output iba_pkg::dp_sts_t                sts_o,
  output logic [iba_pkg::OUT_DATA_W-1:0]  m_tdata_o,
  output logic [iba_pkg::OUT_USER_W-1:0]  m_tuser_o
);
  import iba_pkg::*;

  logic [WORD_BITS-1:0] mem_q [WORDS];
  logic [WORDS-1:0]     row_vld_q;
  logic [WORD_BITS-1:0] rd_data_q;
  logic                 rd_vld_q;
  logic [ADDR_W-1:0]    addr_q;
  logic [ADDR_W-1:0]    chk_addr_q;
  logic [POS_W-1:0]     bit_q;
  logic [NUM_W-1:0]     res_num_q;
  status_e              res_st_q;
  logic [NUM_W-1:0]     out_num_q;
  status_e              out_st_q;

  logic [NUM_W-1:0]     req_num;
  logic [IDX_W-1:0]     req_idx;
  logic [ADDR_W-1:0]    req_addr;
  logic                 free_ok;
  logic                 req_free;
  logic [WORD_BITS-1:0] word;
  logic [WORD_BITS-1:0] free_w;
  logic [7:0]           byte_any;
  logic [2:0]           byte_sel;
  logic [7:0]           sel_bits;
  logic [2:0]           bit_sel;
  logic                 byte_hit;
  logic                 bit_hit;
  logic [POS_W-1:0]     pos;
  logic [31:0]          num_wide;
  logic [WORD_BITS-1:0] wdata;
  logic                 wr_en;
  logic                 last_word;

  assign req_num  = s_tdata_i[NUM_W-1:0];
  assign req_free = (s_tuser_i[0] == KIND_FREE);
  assign req_idx  = IDX_W'(req_num) - IDX_W'(1);
  assign req_addr = req_idx[ADDR_W+POS_W-1:POS_W];
  assign free_ok  = (req_num != '0) && (32'(req_num) <= 32'(TOTAL_BITS));

  assign word = rd_vld_q ? rd_data_q : '0;

  always_comb begin
    logic [31:0] g;
    for (int i = 0; i < WORD_BITS; i++) begin
      g = 32'({chk_addr_q, POS_W'(i)});
      free_w[i] = !(word[i] || (g < 32'(RESERVED_INODES)) || (g >= 32'(TOTAL_BITS)));
    end
  end

  always_comb begin
    for (int j = 0; j < 8; j++) begin
      byte_any[j] = |free_w[j*8 +: 8];
    end
  end

  always_comb begin
    byte_sel = '0;
    byte_hit = 1'b0;
    for (int j = 0; j < 8; j++) begin
      if (!byte_hit && byte_any[j]) begin
        byte_sel = 3'(j);
        byte_hit = 1'b1;
      end
    end
  end

  assign sel_bits = free_w[{byte_sel, 3'b000} +: 8];

  always_comb begin
    bit_sel = '0;
    bit_hit = 1'b0;
    for (int k = 0; k < 8; k++) begin
      if (!bit_hit && sel_bits[k]) begin
        bit_sel = 3'(k);
        bit_hit = 1'b1;
      end
    end
  end

  assign pos       = {byte_sel, bit_sel};
  assign num_wide  = 32'({chk_addr_q, pos}) + 32'd1;
  assign last_word = (chk_addr_q == ADDR_W'(WORDS - 1));
  assign wr_en     = cmd_i.wr_alloc || cmd_i.wr_free;
  assign wdata     = cmd_i.wr_alloc ? (word | (WORD_BITS'(1) << pos))
                                    : (word & ~(WORD_BITS'(1) << bit_q));

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[chk_addr_q] <= wdata;
    end
    rd_data_q <= mem_q[addr_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_vld_q  <= '0;
      rd_vld_q   <= 1'b0;
      addr_q     <= '0;
      chk_addr_q <= '0;
      bit_q      <= '0;
    end else begin
      rd_vld_q   <= row_vld_q[addr_q];
      chk_addr_q <= addr_q;
      if (wr_en) begin
        row_vld_q[chk_addr_q] <= 1'b1;
      end
      if (cmd_i.load_req) begin
        addr_q <= (req_free && free_ok) ? req_addr : '0;
        bit_q  <= req_idx[POS_W-1:0];
      end else if (cmd_i.addr_inc && (addr_q != ADDR_W'(WORDS - 1))) begin
        addr_q <= addr_q + ADDR_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    priority if (cmd_i.res_alloc) begin
      res_num_q <= num_wide[NUM_W-1:0];
      res_st_q  <= STS_ALLOCATED;
    end else if (cmd_i.res_full) begin
      res_num_q <= '0;
      res_st_q  <= STS_FULL;
    end else if (cmd_i.res_freed) begin
      res_num_q <= '0;
      res_st_q  <= STS_FREED;
    end else if (cmd_i.res_ignored) begin
      res_num_q <= '0;
      res_st_q  <= STS_IGNORED;
    end else begin
      res_num_q <= res_num_q;
      res_st_q  <= res_st_q;
    end
    if (cmd_i.out_load) begin
      out_num_q <= res_num_q;
      out_st_q  <= res_st_q;
    end
  end

  assign sts_o.req_free  = req_free;
  assign sts_o.free_ok   = free_ok;
  assign sts_o.found     = byte_hit;
  assign sts_o.last_word = last_word;

  assign m_tdata_o = OUT_DATA_W'(out_num_q);
  assign m_tuser_o = out_st_q;

endmodule

// ===== hdl/iba_ctrl.sv =====
module iba_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_tvalid_i,
  output logic             s_tready_o,
  output logic             m_tvalid_o,
  input  logic             m_tready_i,
  input  iba_pkg::dp_sts_t sts_i,
  output iba_pkg::dp_cmd_t cmd_o
);
  import iba_pkg::*;

  state_e state_q, state_d;
  logic   m_valid_q, m_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    s_tready_o = 1'b0;
    m_valid_d  = m_valid_q && !m_tready_i;
    unique case (state_q)
      S_IDLE: begin
        s_tready_o = 1'b1;
        if (s_tvalid_i) begin
          cmd_o.load_req = 1'b1;
          if (!sts_i.req_free) begin
            state_d = S_PRIME;
          end else if (sts_i.free_ok) begin
            state_d = S_FREE_RD;
          end else begin
            cmd_o.res_ignored = 1'b1;
            state_d           = S_OUT;
          end
        end
      end
      S_PRIME: begin
        cmd_o.addr_inc = 1'b1;
        state_d        = S_SCAN;
      end
      S_SCAN: begin
        if (sts_i.found) begin
          cmd_o.wr_alloc  = 1'b1;
          cmd_o.res_alloc = 1'b1;
          state_d         = S_OUT;
        end else if (sts_i.last_word) begin
          cmd_o.res_full = 1'b1;
          state_d        = S_OUT;
        end else begin
          cmd_o.addr_inc = 1'b1;
        end
      end
      S_FREE_RD: begin
        state_d = S_FREE_WR;
      end
      S_FREE_WR: begin
        cmd_o.wr_free   = 1'b1;
        cmd_o.res_freed = 1'b1;
        state_d         = S_OUT;
      end
      S_OUT: begin
        if (!m_valid_q || m_tready_i) begin
          cmd_o.out_load = 1'b1;
          m_valid_d      = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign m_tvalid_o = m_valid_q;

endmodule

// ===== hdl/inode_bitmap_allocator.sv =====
// Inode bitmap allocator: 4096 in-use bits, bit n-1 for inode n.
// Slave channel takes one request per item: s_tuser_i is the kind (0 allocate,
// 1 free), s_tdata_i carries the inode to free. Master channel returns one
// item per request: m_tdata_o the granted inode (0 if none), m_tuser_o the
// status (0 allocated, 1 full, 2 freed, 3 free ignored).
// Allocate reads the bitmap one 64-bit word a cycle from the lowest word and
// stops at the first word with a clear bit outside the reserved inodes; the
// scan is bound by the single read port of the bitmap memory. Free is a
// read-modify-write of one word. One request is in work at a time; the next
// is accepted as soon as the result moves to the output register, even while
// that result still waits for m_tready_i.
// Reset clears a valid bit per word, so the whole bitmap reads as free at
// once and no clearing pass is needed. While the receiver stalls, the result
// holds in the output register and the next finished request waits in the
// result stage; no further request is accepted until the output register frees.
module inode_bitmap_allocator (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_tvalid_i,
  output logic                            s_tready_o,
  input  logic [iba_pkg::IN_DATA_W-1:0]   s_tdata_i,   // [12:0] inode_number
  input  logic [iba_pkg::IN_USER_W-1:0]   s_tuser_i,   // [0] kind
  output logic                            m_tvalid_o,
  input  logic                            m_tready_i,
  output logic [iba_pkg::OUT_DATA_W-1:0]  m_tdata_o,   // [12:0] allocated_number
  output logic [iba_pkg::OUT_USER_W-1:0]  m_tuser_o    // [1:0] status
);
  import iba_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  iba_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_tvalid_i),
    .s_tready_o (s_tready_o),
    .m_tvalid_o (m_tvalid_o),
    .m_tready_i (m_tready_i),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  iba_dp u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_tdata_i (s_tdata_i),
    .s_tuser_i (s_tuser_i),
    .cmd_i     (cmd),
    .sts_o     (sts),
    .m_tdata_o (m_tdata_o),
    .m_tuser_o (m_tuser_o)
  );

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_tvalid_i && s_tready_o |=> !s_tready_o)
    else $error("request accepted while another is in work");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |-> !m_tvalid_o || m_tready_i)
    else $error("pending result overwritten");

  a_zero_number: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o && m_tuser_o != STS_ALLOCATED |-> m_tdata_o == '0)
    else $error("nonzero inode number without a grant");

  a_single_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.wr_alloc || cmd.wr_free |=> !cmd.wr_alloc && !cmd.wr_free)
    else $error("bitmap written twice for one request");
`endif

endmodule
